// File: sv/centered_moving_mean_defines.svh
// Assertion macros used by the cmm_window RTL.
`ifndef CENTERED_MOVING_MEAN_DEFINES_SVH
`define CENTERED_MOVING_MEAN_DEFINES_SVH
`ifndef ASSERT_OFF
`define CMM_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define CMM_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) pre |=> post) else $error(msg);
`else
`define CMM_ASSERT(label, clk, rst, prop, msg)
`define CMM_ASSERT_NEXT(label, clk, rst, pre, post, msg)
`endif
`endif

// File: sv/cmm_pkg.sv
package cmm_pkg;

   // Field widths
   localparam int SAMPLE_W = 16;
   localparam int WIN_W    = 7;
   localparam int MEAN_W   = 24;
   localparam int FRAC_W   = 8;

   // Window geometry
   localparam int MAX_HALF   = 32;
   localparam int LINE_DEPTH = 2 * MAX_HALF + 1;
   localparam int HALF_W     = $clog2(MAX_HALF + 1);
   localparam int TOP_W      = $clog2(LINE_DEPTH);
   localparam int CNT_W      = $clog2(LINE_DEPTH + 1);

   // Running sum and divider sizes
   localparam int SUM_W     = 23;
   localparam int MAG_W     = SUM_W - 1;
   localparam int DVS_W     = CNT_W + 1;
   localparam int QUO_W     = MEAN_W;
   localparam int NUM_W     = DVS_W + QUO_W;
   localparam int DIV_STEPS = QUO_W;

   localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(5);

   // One delay line entry
   typedef struct packed {
      logic                       miss;
      logic signed [SAMPLE_W-1:0] value;
   } cmm_tap_type;

   // Window sum and count for one result
   typedef struct packed {
      logic                    valid;
      logic signed [SUM_W-1:0] sum;
      logic [CNT_W-1:0]        count;
      logic                    eos;
   } cmm_res_type;

   // One divider stage
   typedef struct packed {
      logic             valid;
      logic [DVS_W-1:0] rem;
      logic [QUO_W-1:0] low;
      logic [QUO_W-1:0] quo;
      logic [DVS_W-1:0] dvs;
      logic             neg;
      logic             empty;
      logic             eos;
   } cmm_div_type;

   // Finished result word
   typedef struct packed {
      logic                     valid;
      logic signed [MEAN_W-1:0] mean_value;
      logic                     empty_res;
      logic                     end_of_stream;
   } cmm_out_type;

endpackage

// File: sv/cmm_ifs.sv
// Sample channel
interface cmm_req_if import cmm_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample;
   logic                       missing;
   logic                       last;

   modport source (output valid, sample, missing, last, input ready);
   modport sink   (input valid, sample, missing, last, output ready);
endinterface

// Result channel
interface cmm_rsp_if import cmm_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [MEAN_W-1:0] mean_value;
   logic                     empty_res;
   logic                     end_of_stream;

   modport source (output valid, mean_value, empty_res, end_of_stream, input ready);
   modport sink   (input valid, mean_value, empty_res, end_of_stream, output ready);
endinterface

// Window length register write channel
interface cmm_csr_if import cmm_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [WIN_W-1:0] window;

   modport source (output valid, window, input ready);
   modport sink   (input valid, window, output ready);
endinterface

// File: sv/cmm_tap_cell.sv
module cmm_tap_cell import cmm_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       shift,
   input  logic                       clear,
   input  logic                       sel,
   input  cmm_tap_type                din,
   output cmm_tap_type                dout,
   output logic                       tap_present,
   output logic signed [SAMPLE_W-1:0] tap_value
);

   cmm_tap_type entry_ff;
   cmm_tap_type entry_in;

   // clear marks the entry missing, shift takes the neighbor's entry
   always_comb begin
      entry_in = entry_ff;
      if (clear) begin
         entry_in.miss = 1'b1;
      end else if (shift) begin
         entry_in = din;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.miss <= 1'b1;
      end else begin
         entry_ff <= entry_in;
      end
   end

   assign dout = entry_ff;

   // gated tap, zero unless this is the selected and present entry
   assign tap_present = sel & ~entry_ff.miss;
   assign tap_value   = tap_present ? entry_ff.value : '0;

endmodule

// File: sv/cmm_window.sv
`include "centered_moving_mean_defines.svh"

module cmm_window import cmm_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             adv,
   input  logic [WIN_W-1:0] window,
   cmm_req_if.sink          req_port,
   output cmm_res_type      res
);

   logic                    active_ff, active_in;
   logic [HALF_W-1:0]       cur_half_ff, half_in;
   logic [HALF_W-1:0]       seen_ff, seen_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic                    flush_ff, flush_in;
   logic [HALF_W-1:0]       flush_left_ff, left_in;
   cmm_res_type             res_ff, res_in;

   logic [HALF_W-1:0]          raw_half, new_half, eff_half;
   logic [TOP_W-1:0]           top_idx;
   logic                       take, step, emit, final_step;
   logic signed [SAMPLE_W-1:0] step_val;
   logic                       step_miss;
   cmm_tap_type                head;
   logic                       leave_present;
   logic signed [SAMPLE_W-1:0] leave_value;
   logic signed [SUM_W-1:0]    sum_step;
   logic [CNT_W-1:0]           count_step;

   cmm_tap_type                line_out [LINE_DEPTH];
   logic [LINE_DEPTH-1:0]      tap_present;
   logic signed [SAMPLE_W-1:0] tap_value [LINE_DEPTH];

   // half width, taken from the register when a stream starts
   assign raw_half = window[WIN_W-1:1];
   assign new_half = (raw_half > HALF_W'(MAX_HALF)) ? HALF_W'(MAX_HALF) : raw_half;
   assign eff_half = active_ff ? cur_half_ff : new_half;
   assign top_idx  = {eff_half, 1'b0};

   // a step is an accepted word or one flush slot
   assign req_port.ready = adv & ~flush_ff;
   assign take       = req_port.valid & req_port.ready;
   assign step       = take | (flush_ff & adv);
   assign step_val   = flush_ff ? '0 : req_port.sample;
   assign step_miss  = flush_ff | req_port.missing;
   assign emit       = (seen_ff >= eff_half);
   assign final_step = step & ((take & req_port.last & (eff_half == '0)) |
                               (flush_ff & (flush_left_ff == HALF_W'(1))));

   assign head.miss  = step_miss;
   assign head.value = step_val;

   // delay line cells
   for (genvar k = 0; k < LINE_DEPTH; k++) begin : g_line
      cmm_tap_type cell_din;
      if (k == 0) begin : g_head
         assign cell_din = head;
      end else begin : g_body
         assign cell_din = line_out[k-1];
      end
      cmm_tap_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .shift       (step),
         .clear       (final_step),
         .sel         (top_idx == TOP_W'(k)),
         .din         (cell_din),
         .dout        (line_out[k]),
         .tap_present (tap_present[k]),
         .tap_value   (tap_value[k])
      );
   end

   // entry leaving the window
   always_comb begin
      leave_value = '0;
      for (int k = 0; k < LINE_DEPTH; k++) begin
         leave_value = leave_value | tap_value[k];
      end
   end
   assign leave_present = |tap_present;

   // running sum and present count
   assign sum_step   = sum_ff - SUM_W'(leave_value) +
                       (step_miss ? SUM_W'(0) : SUM_W'(step_val));
   assign count_step = count_ff - CNT_W'(leave_present) + CNT_W'(!step_miss);

   // stream state
   always_comb begin
      active_in = active_ff;
      half_in   = cur_half_ff;
      seen_in   = seen_ff;
      sum_in    = sum_ff;
      count_in  = count_ff;
      flush_in  = flush_ff;
      left_in   = flush_left_ff;
      if (final_step) begin
         active_in = 1'b0;
         half_in   = '0;
         seen_in   = '0;
         sum_in    = '0;
         count_in  = '0;
         flush_in  = 1'b0;
         left_in   = '0;
      end else if (step) begin
         active_in = 1'b1;
         half_in   = eff_half;
         sum_in    = sum_step;
         count_in  = count_step;
         if (!emit) begin
            seen_in = seen_ff + HALF_W'(1);
         end
         if (take && req_port.last) begin
            flush_in = 1'b1;
            left_in  = eff_half;
         end else if (flush_ff) begin
            left_in = flush_left_ff - HALF_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff     <= 1'b0;
         cur_half_ff   <= '0;
         seen_ff       <= '0;
         sum_ff        <= '0;
         count_ff      <= '0;
         flush_ff      <= 1'b0;
         flush_left_ff <= '0;
      end else begin
         active_ff     <= active_in;
         cur_half_ff   <= half_in;
         seen_ff       <= seen_in;
         sum_ff        <= sum_in;
         count_ff      <= count_in;
         flush_ff      <= flush_in;
         flush_left_ff <= left_in;
      end
   end

   // result stage
   always_comb begin
      res_in.valid = step & emit;
      res_in.sum   = sum_step;
      res_in.count = count_step;
      res_in.eos   = final_step;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         res_ff <= res_in;
      end
      if (reset) begin
         res_ff.valid <= 1'b0;
      end
   end

   assign res = res_ff;

   `CMM_ASSERT(a_count_span, clock, reset, (({1'b0, count_ff}) <= ({1'b0, cur_half_ff, 1'b0} + 8'd1)), "present count exceeds window span")
   `CMM_ASSERT(a_idle_clear, clock, reset, (!active_ff |-> (sum_ff == '0 && count_ff == '0 && seen_ff == '0)), "idle stream state not clear")
   `CMM_ASSERT(a_flush_active, clock, reset, (flush_ff |-> active_ff), "flush outside a stream")
   `CMM_ASSERT_NEXT(a_eos_clears, clock, reset, (adv && res_in.valid && res_in.eos), (!active_ff && !flush_ff), "stream not closed after final word")

endmodule

// File: sv/cmm_div_cell.sv
module cmm_div_cell import cmm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        adv,
   input  cmm_div_type prev,
   output cmm_div_type stage
);

   cmm_div_type      stage_ff, stage_in;
   logic [DVS_W:0]   trial;
   logic             fits;

   // one restoring step: bring down a numerator bit, subtract if it fits
   assign trial = {prev.rem, prev.low[QUO_W-1]};
   assign fits  = (trial >= {1'b0, prev.dvs});

   always_comb begin
      stage_in     = prev;
      stage_in.low = {prev.low[QUO_W-2:0], 1'b0};
      stage_in.quo = {prev.quo[QUO_W-2:0], fits};
      if (fits) begin
         stage_in.rem = DVS_W'(trial - {1'b0, prev.dvs});
      end else begin
         stage_in.rem = trial[DVS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         stage_ff <= stage_in;
      end
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end
   end

   assign stage = stage_ff;

endmodule

// File: sv/cmm_divider.sv
module cmm_divider import cmm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        adv,
   input  cmm_res_type res,
   output cmm_out_type result
);

   cmm_div_type             prep_ff, prep_in;
   cmm_div_type             stage_out [DIV_STEPS];
   cmm_div_type             tail;
   logic                    neg;
   logic signed [SUM_W-1:0] abs_sum;
   logic [NUM_W-1:0]        num;

   // numerator 2*|sum|*256 + count, divisor 2*count
   assign neg     = res.sum[SUM_W-1];
   assign abs_sum = neg ? -res.sum : res.sum;
   assign num     = (NUM_W'(abs_sum[MAG_W-1:0]) << (FRAC_W + 1)) + NUM_W'(res.count);

   always_comb begin
      prep_in.valid = res.valid;
      prep_in.rem   = num[NUM_W-1 -: DVS_W];
      prep_in.low   = num[QUO_W-1:0];
      prep_in.quo   = '0;
      prep_in.dvs   = {res.count, 1'b0};
      prep_in.neg   = neg;
      prep_in.empty = (res.count == '0);
      prep_in.eos   = res.eos;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         prep_ff <= prep_in;
      end
      if (reset) begin
         prep_ff.valid <= 1'b0;
      end
   end

   // one quotient bit per cell
   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
      cmm_div_type cell_prev;
      if (k == 0) begin : g_first
         assign cell_prev = prep_ff;
      end else begin : g_next
         assign cell_prev = stage_out[k-1];
      end
      cmm_div_cell u_cell (
         .clock (clock),
         .reset (reset),
         .adv   (adv),
         .prev  (cell_prev),
         .stage (stage_out[k])
      );
   end

   // sign and empty window
   assign tail = stage_out[DIV_STEPS-1];

   always_comb begin
      result.valid         = tail.valid;
      result.empty_res     = tail.empty;
      result.end_of_stream = tail.eos;
      if (tail.empty) begin
         result.mean_value = '0;
      end else if (tail.neg) begin
         result.mean_value = -tail.quo;
      end else begin
         result.mean_value = tail.quo;
      end
   end

endmodule

// File: sv/centered_moving_mean.sv
// Centered moving mean of a sample stream with missing samples.
// req_port carries one sample word per handshake (sample, missing, last).
// rsp_port returns one mean word per sample, in stream order, as signed
// fixed point with 8 fraction bits; empty_res flags a window with no
// present sample, end_of_stream marks the stream's final result.
// csr_port writes the window length; it is always ready and the new
// length applies from the next stream's first word.
// The result for sample i leaves once sample i+half arrives; on its way to
// rsp_port it passes one window stage, one divider setup stage, 24 one-bit
// divider cells and the output register.
// While streaming and rsp_port is not stalled, one word is taken per cycle.
// A word with last set is followed by half flush steps, with req_port.ready
// low, that push the remaining results into the pipeline.
// When rsp_port stalls, the whole pipeline holds and req_port.ready drops.
// Reset empties the delay line and the pipeline and sets the window to 5.
module centered_moving_mean import cmm_pkg::*; (
   input logic        clock,
   input logic        reset,
   cmm_req_if.sink    req_port,
   cmm_rsp_if.source  rsp_port,
   cmm_csr_if.sink    csr_port
);

   logic [WIN_W-1:0] window_ff;
   cmm_out_type      rsp_ff;
   cmm_res_type      res;
   cmm_out_type      div_out;
   logic             adv;

   // window length register
   assign csr_port.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= WINDOW_RESET;
      end else if (csr_port.valid) begin
         window_ff <= csr_port.window;
      end
   end

   // pipeline moves whenever the output register is free or being read
   assign adv = ~rsp_ff.valid | rsp_port.ready;

   cmm_window u_window (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .window   (window_ff),
      .req_port (req_port),
      .res      (res)
   );

   cmm_divider u_divider (
      .clock  (clock),
      .reset  (reset),
      .adv    (adv),
      .res    (res),
      .result (div_out)
   );

   // output register
   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ff <= div_out;
      end
      if (reset) begin
         rsp_ff.valid <= 1'b0;
      end
   end

   assign rsp_port.valid         = rsp_ff.valid;
   assign rsp_port.mean_value    = rsp_ff.mean_value;
   assign rsp_port.empty_res     = rsp_ff.empty_res;
   assign rsp_port.end_of_stream = rsp_ff.end_of_stream;

endmodule

// File: bench/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import cmm_pkg::*;

   localparam int RANDOM_ITEMS = 400;
   localparam int DRAIN_CYCLES = 80;   // covers the pipeline registers plus a full flush
   localparam int LONG_HOLD    = 300;
   localparam int MAX_REPORTS  = 10;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       missing;
      logic                       last;
   } sample_word_type;

   typedef struct packed {
      logic signed [MEAN_W-1:0] mean_value;
      logic                     empty_res;
      logic                     end_of_stream;
   } mean_word_type;

   logic clock;
   logic reset;

   cmm_req_if req_if ();
   cmm_rsp_if rsp_if ();
   cmm_csr_if csr_if ();

   centered_moving_mean i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_if),
      .rsp_port (rsp_if),
      .csr_port (csr_if)
   );

   sample_word_type pending_words[$];
   mean_word_type   expected_means[$];
   int              words_queued;
   int              words_accepted;
   int              error_count;

   // window model state
   logic signed [SAMPLE_W-1:0] line_value [LINE_DEPTH];
   logic                       line_missing [LINE_DEPTH];
   int                         run_sum;
   int                         run_count;
   int                         fill_count;
   int                         stream_half;
   bit                         stream_open;
   logic [WIN_W-1:0]           window_len;

   // sender burst control
   int burst_left;
   int gap_left;

   // receiver stall control
   int         stall_mode;
   int         mode_left;
   int         hold_count;
   logic [1:0] tick;
   bit         hold_armed;
   bit         hold_done;

   // clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // hard stop
   initial begin
      #2000000;
      $display("RESULT: ERROR");
      $finish;
   end

   function automatic void clear_stream_state();
      for (int k = 0; k < LINE_DEPTH; k++) begin
         line_value[k]   = '0;
         line_missing[k] = 1'b1;
      end
      run_sum     = 0;
      run_count   = 0;
      fill_count  = 0;
      stream_half = 0;
      stream_open = 1'b0;
   endfunction

   // mean of the present samples, 8 fraction bits, ties away from zero
   function automatic mean_word_type window_mean(bit eos);
      mean_word_type r;
      longint        num;
      longint        mag;
      longint        q;
      q = 0;
      if (run_count > 0) begin
         num = longint'(run_sum) * 256;
         mag = (num < 0) ? -num : num;
         q   = (2 * mag + run_count) / (2 * run_count);
         if (num < 0) q = -q;
      end
      r.mean_value    = q[MEAN_W-1:0];
      r.empty_res     = (run_count == 0);
      r.end_of_stream = eos;
      return r;
   endfunction

   // one delay line step; emits a mean once the line holds half samples
   function automatic void shift_sample(logic signed [SAMPLE_W-1:0] val, logic miss, bit eos);
      int            top;
      mean_word_type res_word;
      top = 2 * stream_half;
      if (!line_missing[top]) begin
         run_sum   -= int'(line_value[top]);
         run_count -= 1;
      end
      for (int k = top; k > 0; k--) begin
         line_value[k]   = line_value[k-1];
         line_missing[k] = line_missing[k-1];
      end
      line_value[0]   = miss ? '0 : val;
      line_missing[0] = miss;
      if (!miss) begin
         run_sum   += int'(val);
         run_count += 1;
      end
      if (fill_count >= stream_half) begin
         res_word       = window_mean(eos);
         expected_means = {expected_means, res_word};
      end else begin
         fill_count++;
      end
   endfunction

   // half is latched on the first word of a stream; last flushes the rest
   function automatic void predict_word(sample_word_type w);
      int h;
      if (!stream_open) begin
         h           = int'(window_len) / 2;
         stream_half = (h > MAX_HALF) ? MAX_HALF : h;
         stream_open = 1'b1;
      end
      shift_sample(w.sample, w.missing, w.last && stream_half == 0);
      if (w.last) begin
         for (int t = 0; t < stream_half; t++) shift_sample('0, 1'b1, t == stream_half - 1);
         clear_stream_state();
      end
   endfunction

   // sender: bursts of random length, random gaps
   always @(posedge clock) begin
      sample_word_type next_word;
      if (reset) begin
         req_if.valid   <= 1'b0;
         req_if.sample  <= '0;
         req_if.missing <= 1'b0;
         req_if.last    <= 1'b0;
         burst_left     <= 0;
         gap_left       <= 0;
      end else if (!req_if.valid || req_if.ready) begin
         if (gap_left != 0 || pending_words.size() == 0) begin
            req_if.valid <= 1'b0;
            if (gap_left != 0) gap_left <= gap_left - 1;
         end else begin
            next_word = pending_words.pop_front();
            req_if.valid   <= 1'b1;
            req_if.sample  <= next_word.sample;
            req_if.missing <= next_word.missing;
            req_if.last    <= next_word.last;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 48);
               gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
               burst_left <= burst_left - 1;
            end
         end
      end
   end

   // receiver: stall pattern changes at random intervals; one long hold
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_mode   <= 0;
         mode_left    <= 0;
         hold_count   <= 0;
         hold_done    <= 1'b0;
         tick         <= '0;
      end else begin
         tick <= tick + 1'b1;
         if (hold_armed && !hold_done) begin
            rsp_if.ready <= 1'b0;
            if (hold_count == LONG_HOLD) hold_done <= 1'b1;
            else hold_count <= hold_count + 1;
         end else begin
            if (mode_left == 0) begin
               stall_mode <= $urandom_range(0, 3);
               mode_left  <= $urandom_range(16, 96);
            end else begin
               mode_left <= mode_left - 1;
            end
            case (stall_mode)
               0: rsp_if.ready <= 1'b1;
               1: rsp_if.ready <= 1'($urandom_range(0, 1));
               2: rsp_if.ready <= (tick == 2'd0);
               default: rsp_if.ready <= ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   // monitor: accepted words, register writes, result words
   always @(posedge clock) begin
      sample_word_type in_word;
      mean_word_type   got;
      mean_word_type   want;
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            in_word.sample  = req_if.sample;
            in_word.missing = req_if.missing;
            in_word.last    = req_if.last;
            predict_word(in_word);
            words_accepted++;
         end
         if (csr_if.valid && csr_if.ready) window_len = csr_if.window;
         if (rsp_if.valid && rsp_if.ready) begin
            got.mean_value    = rsp_if.mean_value;
            got.empty_res     = rsp_if.empty_res;
            got.end_of_stream = rsp_if.end_of_stream;
            if (expected_means.size() == 0) begin
               if (error_count < MAX_REPORTS)
                  $display("unexpected result word: mean %0d empty %0b eos %0b",
                           got.mean_value, got.empty_res, got.end_of_stream);
               error_count++;
            end else begin
               want = expected_means.pop_front();
               if (got.mean_value !== want.mean_value || got.empty_res !== want.empty_res ||
                   got.end_of_stream !== want.end_of_stream) begin
                  if (error_count < MAX_REPORTS)
                     $display("mismatch: expected %0d/%0b/%0b got %0d/%0b/%0b",
                              want.mean_value, want.empty_res, want.end_of_stream,
                              got.mean_value, got.empty_res, got.end_of_stream);
                  error_count++;
               end
            end
         end
      end
   end

   task automatic add_word(logic signed [SAMPLE_W-1:0] s, logic m, logic l);
      sample_word_type w;
      w.sample  = s;
      w.missing = m;
      w.last    = l;
      pending_words = {pending_words, w};
      words_queued++;
   endtask

   function automatic logic signed [SAMPLE_W-1:0] random_sample(int style);
      logic signed [SAMPLE_W-1:0] v;
      case (style)
         0: v = SAMPLE_W'($urandom_range(0, 65535));
         1: v = SAMPLE_W'(int'($urandom_range(0, 8)) - 4);
         default: begin
            case ($urandom_range(0, 3))
               0: v = 16'sh7FFF;
               1: v = 16'sh8000;
               2: v = 16'sh7FFE;
               default: v = 16'sh8001;
            endcase
         end
      endcase
      return v;
   endfunction

   // miss_style: none, sparse, half, nearly all
   task automatic add_stream(int len, int miss_style, int val_style, bit close);
      logic m;
      for (int i = 0; i < len; i++) begin
         case (miss_style)
            0: m = 1'b0;
            1: m = ($urandom_range(0, 7) == 0);
            2: m = 1'($urandom_range(0, 1));
            default: m = ($urandom_range(0, 15) != 0);
         endcase
         add_word(random_sample(val_style), m, close && i == len - 1);
      end
   endtask

   // wait until every word is taken and every result is back, then let the pipe drain
   task automatic settle();
      while (words_accepted != words_queued || expected_means.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_window(logic [WIN_W-1:0] w);
      settle();
      csr_if.valid  <= 1'b1;
      csr_if.window <= w;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
   endtask

   initial begin
      int rand_words;
      int phase_no;
      int h;
      int n_streams;
      int len;
      int w;
      int pick;
      bit close;

      reset          = 1'b1;
      csr_if.valid   = 1'b0;
      csr_if.window  = '0;
      words_queued   = 0;
      words_accepted = 0;
      error_count    = 0;
      hold_armed     = 1'b0;
      window_len     = WINDOW_RESET;
      clear_stream_state();

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset window: extremes, a missing word, negative rounding
      add_word(16'sh7FFF, 1'b0, 1'b0);
      add_word(16'sh8000, 1'b0, 1'b0);
      add_word(16'sh0000, 1'b1, 1'b0);
      add_word(16'sh7FFF, 1'b0, 1'b0);
      add_word(16'sh8001, 1'b0, 1'b1);
      // windows of 0 and 1: half is 0, so each mean is its own sample or empty
      set_window(7'd0);
      add_word(16'sh1234, 1'b0, 1'b0);
      add_word(16'sh5555, 1'b1, 1'b1);
      set_window(7'd1);
      add_word(16'sh8000, 1'b0, 1'b1);
      // widest window, then a length far past the half limit; short streams
      set_window(7'd64);
      add_word(16'shFFFF, 1'b0, 1'b1);
      set_window(7'd127);
      add_word(16'sh0005, 1'b0, 1'b0);
      add_word(16'shFFFB, 1'b1, 1'b1);
      // even window
      set_window(7'd6);
      add_word(16'sh0003, 1'b0, 1'b0);
      add_word(-16'sd7, 1'b0, 1'b0);
      add_word(16'sh0000, 1'b1, 1'b0);
      add_word(16'sh00FF, 1'b0, 1'b1);
      // nothing present: empty windows
      set_window(7'd3);
      add_word(16'sh7FFF, 1'b1, 1'b0);
      add_word(16'sh8000, 1'b1, 1'b0);
      add_word(16'shAAAA, 1'b1, 1'b1);
      // write mid-stream: the open stream keeps its half, the next one picks it up
      set_window(7'd5);
      add_word(16'sd10, 1'b0, 1'b0);
      add_word(16'sd20, 1'b0, 1'b0);
      add_word(-16'sd30, 1'b0, 1'b0);
      set_window(7'd9);
      add_word(16'sd40, 1'b0, 1'b0);
      add_word(-16'sd50, 1'b0, 1'b1);
      add_word(16'sd60, 1'b0, 1'b0);
      add_word(-16'sd70, 1'b0, 1'b1);

      // random phases: new window each, a few streams, some left open
      phase_no   = 0;
      rand_words = 0;
      while (rand_words < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 9);
         if (phase_no == 2) begin
            w = 64;
         end else if (pick == 0) begin
            case ($urandom_range(0, 5))
               0: w = 0;
               1: w = 1;
               2: w = 2;
               3: w = 64;
               4: w = 65;
               default: w = 127;
            endcase
         end else if (pick == 1) begin
            w = $urandom_range(21, 127);
         end else begin
            w = $urandom_range(0, 20);
         end
         set_window(WIN_W'(w));
         h = (w / 2 > MAX_HALF) ? MAX_HALF : w / 2;
         if (phase_no == 2) begin
            // receiver holds off while a long stream backs up the pipeline
            hold_armed = 1'b1;
            add_stream(120, 1, 0, 1'b1);
            rand_words += 120;
         end else begin
            n_streams = $urandom_range(1, 4);
            for (int s = 0; s < n_streams; s++) begin
               len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3)
                                                 : $urandom_range(1, 2 * h + 8);
               close = (s < n_streams - 1) || ($urandom_range(0, 4) != 0);
               add_stream(len, $urandom_range(0, 3), $urandom_range(0, 2), close);
               rand_words += len;
            end
         end
         phase_no++;
      end

      settle();
      if (error_count == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

endmodule
